// ===== src/lbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpg_pkg
// Shared types and constants for the LED blink pattern generator.
// ----------------------------------------------------------------------------
package lbpg_pkg;

	localparam int PERIOD_BITS = 16;
	localparam int ENABLE_BITS = 4;
	localparam int ADD_BITS    = 8;
	localparam int BRIGHT_BITS = 8;
	// span * 510 with span at most half of a 16-bit period
	localparam int PROD_BITS   = 25;
	localparam int CFG_IDX_BITS = 2;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ADD  = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] REG_SINGLE_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENDLESS_PERIOD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_ENABLE = 2'd2;

	localparam int EN_FULL  = 0;
	localparam int EN_LONG  = 1;
	localparam int EN_SHORT = 2;
	localparam int EN_WAVE  = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MOD,
		ST_BRIGHT,
		ST_DONE
	} state_t;

endpackage

// ===== src/lbpg_divider.sv =====
// ----------------------------------------------------------------------------
// lbpg_divider
// Restoring radix-2 divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module lbpg_divider
	import lbpg_pkg::*;
#(
	parameter int DW = 32,
	parameter int CW = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DW-1:0]          dividend,
	input  logic [CW-1:0]          nbits,
	input  logic [PERIOD_BITS-1:0] divisor,
	output logic                   done,
	output logic [PERIOD_BITS-1:0] remainder,
	output logic [BRIGHT_BITS-1:0] quotient
);

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic [DW-1:0]          dvd_q;
	logic [PERIOD_BITS-1:0] rem_q;
	logic [BRIGHT_BITS-1:0] quo_q;

	logic [PERIOD_BITS:0] trial;
	logic [PERIOD_BITS:0] diff;
	logic                 ge;

	// dividend enters left aligned, msb first
	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= ge ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
			quo_q <= {quo_q[BRIGHT_BITS-2:0], ge};
		end else if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
	assign quotient  = quo_q;

endmodule

// ===== src/led_blink_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// led_blink_pattern_generator
// LED drive sequencer: counted blinks first, else an endless wave or on/off
// pattern derived from the tick count modulo the endless period.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        in         in_valid/in_ready    command, tick_count, blink_count
//  out       out        out_valid/out_ready  pwm_mode, led_high, brightness
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  add: ST_EVAL, back to idle, no output. counted tick: the same, but once
//  its cycle has started it passes ST_DONE to load the output. endless
//  on/off: ST_MOD, ST_DONE; wave: ST_MOD, ST_BRIGHT, ST_DONE, on the shared
//  bit-serial divider (modulo, then brightness quotient). one transaction in
//  flight; in_ready only when idle. a finished result waits for a free output
//  register. reset clears state and configuration; cfg_ready is always high.
// ----------------------------------------------------------------------------
module led_blink_pattern_generator
	import lbpg_pkg::*;
#(
	parameter int TICK_BITS  = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic [31:0]             tick_count,
	input  logic [ADD_BITS-1:0]     blink_count,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    pwm_mode,
	output logic                    led_high,
	output logic [BRIGHT_BITS-1:0]  brightness,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [PERIOD_BITS-1:0]  cfg_data
);

	localparam int IN_BITS = (TICK_BITS < 32) ? TICK_BITS : 32;
	localparam int DW      = (TICK_BITS > PROD_BITS) ? TICK_BITS : PROD_BITS;
	localparam int CW      = $clog2(DW + 1);

	state_t state_q, state_d;

	logic [PERIOD_BITS-1:0] single_period_q;
	logic [PERIOD_BITS-1:0] endless_period_q;
	logic [ENABLE_BITS-1:0] enable_q;

	logic [COUNT_BITS-1:0] blinks_q;
	logic                  cycle_started_q;
	logic [TICK_BITS-1:0]  start_tick_q;

	logic                  cmd_q;
	logic [TICK_BITS-1:0]  tick_q;
	logic [ADD_BITS-1:0]   add_q;

	logic                   res_led_q;
	logic                   res_pwm_q;
	logic [BRIGHT_BITS-1:0] res_bright_q;

	logic                   out_valid_q;
	logic                   out_pwm_q;
	logic                   out_led_q;
	logic [BRIGHT_BITS-1:0] out_bright_q;

	logic                   div_start;
	logic [DW-1:0]          div_dvd;
	logic [CW-1:0]          div_nbits;
	logic                   div_done;
	logic [PERIOD_BITS-1:0] div_rem;
	logic [BRIGHT_BITS-1:0] div_quo;

	logic counted_act;
	logic endless_act;
	logic wave_en;
	logic out_free;

	// counted blink terms
	logic [TICK_BITS-1:0]   d_full;
	logic                   d_hi;
	logic [PERIOD_BITS-1:0] d16;
	logic [19:0]            ten_d;
	logic [19:0]            three_p;
	logic                   blink_on;
	logic                   d_ge_p;

	// endless terms, x is the modulo remainder
	logic [PERIOD_BITS-1:0] x;
	logic [PERIOD_BITS-1:0] span;
	logic [PROD_BITS-1:0]   prod;
	logic                   win_long;
	logic                   win_short;
	logic                   pat_on;

	logic [COUNT_BITS:0]    blink_sum;

	assign counted_act = (single_period_q != '0) && (blinks_q != '0);
	assign endless_act = endless_period_q != '0;
	assign wave_en     = enable_q[EN_WAVE];
	assign out_free    = !out_valid_q || out_ready;

	assign d_full   = tick_q - start_tick_q;
	assign d_hi     = (d_full >> PERIOD_BITS) != '0;
	assign d16      = d_full[PERIOD_BITS-1:0];
	assign ten_d    = 20'({d16, 3'b000}) + 20'({d16, 1'b0});
	assign three_p  = 20'({single_period_q, 1'b0}) + 20'(single_period_q);
	assign blink_on = !d_hi && (ten_d < three_p);
	assign d_ge_p   = d_hi || (d16 >= single_period_q);

	assign x    = div_rem;
	assign span = (x > (endless_period_q >> 1)) ? (endless_period_q - x) : x;
	assign prod = PROD_BITS'({span, 9'b0}) - PROD_BITS'({span, 1'b0});

	assign win_long  = (19'({x, 2'b00}) + 19'(x)) < 19'(endless_period_q);
	assign win_short = (17'({x, 1'b0}) >= 17'(endless_period_q)) &&
		((21'({x, 4'b0000}) + 21'({x, 2'b00})) <
		 (21'({endless_period_q, 3'b000}) + 21'({endless_period_q, 1'b0}) +
		  21'(endless_period_q)));
	assign pat_on = enable_q[EN_FULL] || (enable_q[EN_LONG] && win_long) ||
		(enable_q[EN_SHORT] && win_short);

	assign blink_sum = (COUNT_BITS + 1)'(blinks_q) + (COUNT_BITS + 1)'(add_q);

	lbpg_divider #(
		.DW (DW),
		.CW (CW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.nbits     (div_nbits),
		.divisor   (endless_period_q),
		.done      (div_done),
		.remainder (div_rem),
		.quotient  (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		div_dvd   = DW'(tick_q) << (DW - TICK_BITS);
		div_nbits = CW'(TICK_BITS);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (cmd_q == CMD_ADD) begin
					state_d = ST_IDLE;
				end else if (counted_act) begin
					// first tick of a run only records the start time
					state_d = cycle_started_q ? ST_DONE : ST_IDLE;
				end else if (endless_act) begin
					div_start = 1'b1;
					state_d   = ST_MOD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MOD: begin
				div_dvd   = DW'(prod) << (DW - PROD_BITS);
				div_nbits = CW'(PROD_BITS);
				if (div_done) begin
					if (wave_en) begin
						div_start = 1'b1;
						state_d   = ST_BRIGHT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_BRIGHT: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_period_q  <= '0;
			endless_period_q <= '0;
			enable_q         <= '0;
			blinks_q         <= '0;
			cycle_started_q  <= 1'b0;
			start_tick_q     <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SINGLE_PERIOD:  single_period_q  <= cfg_data;
					REG_ENDLESS_PERIOD: endless_period_q <= cfg_data;
					REG_PATTERN_ENABLE: enable_q         <= cfg_data[ENABLE_BITS-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_EVAL) begin
				if (cmd_q == CMD_ADD) begin
					blinks_q <= blink_sum[COUNT_BITS] ? '1 : blink_sum[COUNT_BITS-1:0];
				end else if (counted_act) begin
					if (!cycle_started_q) begin
						cycle_started_q <= 1'b1;
						start_tick_q    <= tick_q;
					end else if (d_ge_p) begin
						blinks_q <= blinks_q - COUNT_BITS'(1);
						if (blinks_q == COUNT_BITS'(1)) begin
							cycle_started_q <= 1'b0;
						end else begin
							start_tick_q <= start_tick_q + TICK_BITS'(single_period_q);
						end
					end
				end
			end
		end
	end

	// captured transaction and pending result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= command;
			tick_q <= TICK_BITS'(tick_count[IN_BITS-1:0]);
			add_q  <= blink_count;
		end
		if (state_q == ST_EVAL) begin
			res_pwm_q    <= 1'b0;
			res_led_q    <= blink_on;
			res_bright_q <= '0;
		end
		if (state_q == ST_MOD && div_done && !wave_en) begin
			res_pwm_q    <= 1'b0;
			res_led_q    <= pat_on;
			res_bright_q <= '0;
		end
		if (state_q == ST_BRIGHT && div_done) begin
			res_pwm_q    <= 1'b1;
			res_led_q    <= 1'b0;
			res_bright_q <= div_quo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_pwm_q    <= res_pwm_q;
			out_led_q    <= res_led_q;
			out_bright_q <= res_bright_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pwm_mode   = out_pwm_q;
	assign led_high   = out_led_q;
	assign brightness = out_bright_q;
	assign cfg_ready  = 1'b1;

	// a running cycle always has blinks left
	a_started_has_blinks: assert property (@(posedge clk) disable iff (!arst_n)
		cycle_started_q |-> (blinks_q != '0))
		else $error("cycle running with no blinks left");

	// divider finishes only while the sequencer waits for it
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_MOD || state_q == ST_BRIGHT))
		else $error("divider result with no waiting step");

	// an accepted transaction is evaluated in the next cycle
	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EVAL))
		else $error("accepted transaction not evaluated");

endmodule
